>>> src/rort_pkg.sv
// ============================================================================
// rort_pkg
// Shared types and constants of the range offset remap table: table depth,
// field widths, operation codes, register indexes and pipeline controls.
// ============================================================================
package rort_pkg;

   // table geometry
   localparam int ENTRIES = 64;
   localparam int GRP     = 8;
   localparam int NGRP    = (ENTRIES + GRP - 1) / GRP;

   // field widths
   localparam int DATA_W  = 64;
   localparam int SLOT_W  = 6;
   localparam int CNT_W   = 7;
   localparam int IDX_W   = 9;
   localparam int CSR_W   = 32;
   localparam int ADDR_W  = 3;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [DATA_W-1:0] data_type;

   // operation codes carried by req_op
   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_XLATE = 1'b1
   } op_type;

   // register index, taken from address bit 2
   localparam logic CSR_ENTRIES_IN_USE = 1'b0;

   // load enables of the selection stages
   typedef struct packed {
      logic ld3;
      logic ld4;
   } sel_ctrl_type;

endpackage

>>> src/rort_table.sv
// ============================================================================
// rort_table
// Segment storage with one comparator per segment. A write commits one
// segment; every cycle each segment checks the stage-one value against its
// source interval and reports a match.
// ============================================================================
module rort_table (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [rort_pkg::SLOT_W-1:0]             slot,
   input  logic [rort_pkg::DATA_W-1:0]             dest,
   input  logic [rort_pkg::DATA_W-1:0]             src,
   input  logic [rort_pkg::DATA_W-1:0]             span,
   input  logic [rort_pkg::DATA_W-1:0]             value,
   input  logic [rort_pkg::CNT_W-1:0]              entries_in_use,
   output logic [rort_pkg::ENTRIES-1:0]            match,
   output rort_pkg::data_type                      delta [rort_pkg::ENTRIES]
);

   logic [rort_pkg::DATA_W-1:0] wr_delta;

   // store the destination as an offset from the source start
   assign wr_delta = dest - src;

   for (genvar i = 0; i < rort_pkg::ENTRIES; i++) begin : g_seg
      logic [rort_pkg::DATA_W-1:0] src_ff, src_in;
      logic [rort_pkg::DATA_W-1:0] len_ff, len_in;
      logic [rort_pkg::DATA_W-1:0] delta_ff, delta_in;
      logic [rort_pkg::DATA_W-1:0] off;
      logic                        sel;

      // load this segment on a write to its slot
      assign sel = we && (rort_pkg::idx_type'(slot) == rort_pkg::idx_type'(i));

      always_comb begin
         src_in   = sel ? src      : src_ff;
         len_in   = sel ? span     : len_ff;
         delta_in = sel ? wr_delta : delta_ff;
      end

      always_ff @(posedge clock) begin
         src_ff   <= src_in;
         len_ff   <= len_in;
         delta_ff <= delta_in;
      end

      // match when in use and the wrapped offset is below the length
      assign off      = value - src_ff;
      assign match[i] = (off < len_ff) &&
                        (rort_pkg::idx_type'(i) < rort_pkg::idx_type'(entries_in_use));
      assign delta[i] = delta_ff;
   end

endmodule

>>> src/rort_select.sv
// ============================================================================
// rort_select
// Two-level registered priority tree. The first level picks the lowest
// matching segment in each group of eight, the second the lowest matching
// group, and hands on the hit flag with the chosen offset.
// ============================================================================
module rort_select (
   input  logic                                 clock,
   input  rort_pkg::sel_ctrl_type               ctrl,
   input  logic [rort_pkg::ENTRIES-1:0]         hit_vec,
   input  rort_pkg::data_type                   delta [rort_pkg::ENTRIES],
   output logic                                 hit,
   output logic [rort_pkg::DATA_W-1:0]          delta_sel
);

   logic [rort_pkg::NGRP-1:0]   ghit_new, ghit_in, ghit_ff;
   rort_pkg::data_type          gdelta_new [rort_pkg::NGRP];
   rort_pkg::data_type          gdelta_in  [rort_pkg::NGRP];
   rort_pkg::data_type          gdelta_ff  [rort_pkg::NGRP];
   logic                        hit_new, hit_in, hit_ff;
   logic [rort_pkg::DATA_W-1:0] delta_new, delta_in, delta_ff;

   // pick the lowest matching segment within each group
   always_comb begin
      int k;
      k = 0;
      for (int g = 0; g < rort_pkg::NGRP; g++) begin
         ghit_new[g]   = 1'b0;
         gdelta_new[g] = '0;
         for (int j = rort_pkg::GRP - 1; j >= 0; j--) begin
            k = g * rort_pkg::GRP + j;
            if (k < rort_pkg::ENTRIES) begin
               if (hit_vec[k]) begin
                  ghit_new[g]   = 1'b1;
                  gdelta_new[g] = delta[k];
               end
            end
         end
      end
   end

   always_comb begin
      ghit_in = ctrl.ld3 ? ghit_new : ghit_ff;
      for (int g = 0; g < rort_pkg::NGRP; g++) begin
         gdelta_in[g] = ctrl.ld3 ? gdelta_new[g] : gdelta_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      ghit_ff   <= ghit_in;
      gdelta_ff <= gdelta_in;
   end

   // pick the lowest matching group
   always_comb begin
      hit_new   = 1'b0;
      delta_new = '0;
      for (int g = rort_pkg::NGRP - 1; g >= 0; g--) begin
         if (ghit_ff[g]) begin
            hit_new   = 1'b1;
            delta_new = gdelta_ff[g];
         end
      end
   end

   always_comb begin
      hit_in   = ctrl.ld4 ? hit_new   : hit_ff;
      delta_in = ctrl.ld4 ? delta_new : delta_ff;
   end

   always_ff @(posedge clock) begin
      hit_ff   <= hit_in;
      delta_ff <= delta_in;
   end

   assign hit       = hit_ff;
   assign delta_sel = delta_ff;

endmodule

>>> src/range_offset_remap_table_top.sv
// ============================================================================
// range_offset_remap_table_top
// Remap table of segments (source start, destination start, length) with a
// pipelined lookup that maps a value into the lowest matching segment.
// ============================================================================
// Usage:
//   req_* carries one transaction per valid/ready handshake. req_op selects a
//   segment write (slot, dest_start, source_start, span) or a translate
//   (value). A write gives no response; a translate gives one rsp_*
//   transaction with rsp_mapped and rsp_hit, in request order.
//   csr_* is an APB-style port; entries_in_use at address 0 sets how many
//   segments, from slot 0 upward, take part in matching. Write it while idle.
// Pipeline: a translate passes the input register, per-segment compare,
//   group select, final select, then the add into the response register.
// Throughput: one transaction per cycle unless rsp_ready stalls; a write
//   commits to the table when it leaves the input register, so a translate
//   right behind it sees it.
// Reset: clears all pipeline valid bits and entries_in_use; table contents
//   stay undefined until written.
// Stall: when rsp_ready is low the stages fill up one by one, bubbles close,
//   and req_ready drops once every stage holds a transaction; a write held in
//   the input register commits only when the compare stage can load.
// ============================================================================
module range_offset_remap_table_top (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_op,
   input  logic [rort_pkg::SLOT_W-1:0]       req_slot,
   input  logic [rort_pkg::DATA_W-1:0]       req_dest_start,
   input  logic [rort_pkg::DATA_W-1:0]       req_source_start,
   input  logic [rort_pkg::DATA_W-1:0]       req_span,
   input  logic [rort_pkg::DATA_W-1:0]       req_value,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rort_pkg::DATA_W-1:0]       rsp_mapped,
   output logic                              rsp_hit,
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rort_pkg::ADDR_W-1:0]       csr_paddr,
   input  logic [rort_pkg::CSR_W-1:0]        csr_pwdata,
   output logic [rort_pkg::CSR_W-1:0]        csr_prdata,
   output logic                              csr_pready
);

   // load enables
   logic ld1, ld2, ld3, ld4, ld_out;

   // stage registers
   logic                        v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   logic                        op1_ff, op1_in;
   logic [rort_pkg::SLOT_W-1:0] slot1_ff, slot1_in;
   logic [rort_pkg::DATA_W-1:0] dest1_ff, dest1_in, src1_ff, src1_in, span1_ff, span1_in;
   logic [rort_pkg::DATA_W-1:0] val1_ff, val1_in, val2_ff, val2_in;
   logic [rort_pkg::DATA_W-1:0] val3_ff, val3_in, val4_ff, val4_in;
   logic [rort_pkg::ENTRIES-1:0] hv2_ff, hv2_in;
   logic                        rsp_valid_ff, rsp_valid_in, rsp_hit_ff, rsp_hit_in;
   logic [rort_pkg::DATA_W-1:0] rsp_mapped_ff, rsp_mapped_in;
   logic [rort_pkg::CNT_W-1:0]  eiu_ff, eiu_in;

   logic                        wr_commit, is_write1, is_xlate1;
   logic [rort_pkg::ENTRIES-1:0] match;
   rort_pkg::data_type          delta [rort_pkg::ENTRIES];
   rort_pkg::sel_ctrl_type      sel_ctrl;
   logic                        sel_hit;
   logic [rort_pkg::DATA_W-1:0] sel_delta;
   logic                        csr_wr;

   // backpressure: a stage loads when empty or when its content moves on
   assign is_write1 = (op1_ff == rort_pkg::OP_WRITE);
   assign is_xlate1 = (op1_ff == rort_pkg::OP_XLATE);
   assign ld_out    = !rsp_valid_ff || rsp_ready;
   assign ld4       = !v4_ff || ld_out;
   assign ld3       = !v3_ff || ld4;
   assign ld2       = !v2_ff || ld3;
   assign ld1       = !v1_ff || ld2;
   assign req_ready = ld1;

   assign sel_ctrl.ld3 = ld3;
   assign sel_ctrl.ld4 = ld4;

   // commit a write as it leaves the input register, never under a held compare
   assign wr_commit = v1_ff && is_write1 && ld2;

   // input register
   always_comb begin
      v1_in    = ld1 ? req_valid        : v1_ff;
      op1_in   = ld1 ? req_op           : op1_ff;
      slot1_in = ld1 ? req_slot         : slot1_ff;
      dest1_in = ld1 ? req_dest_start   : dest1_ff;
      src1_in  = ld1 ? req_source_start : src1_ff;
      span1_in = ld1 ? req_span         : span1_ff;
      val1_in  = ld1 ? req_value        : val1_ff;
   end

   // compare stage: only translates travel on
   always_comb begin
      v2_in  = ld2 ? (v1_ff && is_xlate1) : v2_ff;
      hv2_in = ld2 ? match                : hv2_ff;
      val2_in = ld2 ? val1_ff             : val2_ff;
   end

   // selection stages: carry the value alongside the tree
   always_comb begin
      v3_in   = ld3 ? v2_ff   : v3_ff;
      val3_in = ld3 ? val2_ff : val3_ff;
      v4_in   = ld4 ? v3_ff   : v4_ff;
      val4_in = ld4 ? val3_ff : val4_ff;
   end

   // response register: add the offset on a hit, else pass the value
   always_comb begin
      rsp_valid_in  = ld_out ? v4_ff : rsp_valid_ff;
      rsp_hit_in    = ld_out ? sel_hit : rsp_hit_ff;
      rsp_mapped_in = ld_out ? (sel_hit ? (val4_ff + sel_delta) : val4_ff) : rsp_mapped_ff;
   end

   // register port: single register at addresses with bit 2 clear, others ignored
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign eiu_in     = (csr_wr && (csr_paddr[2] == rort_pkg::CSR_ENTRIES_IN_USE))
                       ? csr_pwdata[rort_pkg::CNT_W-1:0] : eiu_ff;
   assign csr_prdata = (csr_paddr[2] == rort_pkg::CSR_ENTRIES_IN_USE)
                       ? rort_pkg::CSR_W'(eiu_ff) : '0;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         eiu_ff       <= '0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         v4_ff        <= v4_in;
         rsp_valid_ff <= rsp_valid_in;
         eiu_ff       <= eiu_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op1_ff        <= op1_in;
      slot1_ff      <= slot1_in;
      dest1_ff      <= dest1_in;
      src1_ff       <= src1_in;
      span1_ff      <= span1_in;
      val1_ff       <= val1_in;
      hv2_ff        <= hv2_in;
      val2_ff       <= val2_in;
      val3_ff       <= val3_in;
      val4_ff       <= val4_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_mapped_ff <= rsp_mapped_in;
   end

   rort_table u_table (
      .clock          (clock),
      .we             (wr_commit),
      .slot           (slot1_ff),
      .dest           (dest1_ff),
      .src            (src1_ff),
      .span           (span1_ff),
      .value          (val1_ff),
      .entries_in_use (eiu_ff),
      .match          (match),
      .delta          (delta)
   );

   rort_select u_select (
      .clock     (clock),
      .ctrl      (sel_ctrl),
      .hit_vec   (hv2_ff),
      .delta     (delta),
      .hit       (sel_hit),
      .delta_sel (sel_delta)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_hit    = rsp_hit_ff;
   assign rsp_mapped = rsp_mapped_ff;

endmodule
